// File: rtl/core/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// Shared widths, defaults and codes for the deadline tick scheduler.
// ----------------------------------------------------------------------------
package dts_pkg;

  // Default parameter values
  localparam int unsigned DEF_TIME_WIDTH  = 64;
  localparam int unsigned DEF_COUNT_WIDTH = 32;

  // Fixed port field widths
  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned NOW_W      = 64;
  localparam int unsigned DUE_W      = 32;
  localparam int unsigned SKIP_W     = 32;
  localparam int unsigned OUT_DATA_W = DUE_W + SKIP_W;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_TICK_PERIOD   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CATCHUP_LIMIT = 2'd1;

  // Register defaults
  localparam logic [CFG_DATA_W-1:0] DEFAULT_PERIOD = 64'd1000000;
  localparam logic [CFG_DATA_W-1:0] DEFAULT_LIMIT  = 64'd1;

  // Action codes carried in tuser
  typedef enum logic [ACTION_W-1:0] {
    ACT_START = 2'd0,
    ACT_STOP  = 2'd1,
    ACT_QUERY = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

endpackage

// File: rtl/core/dts_addsub.sv
// ----------------------------------------------------------------------------
// dts_addsub
// Shared adder/subtractor; every time step of the scheduler goes through it.
// ----------------------------------------------------------------------------
module dts_addsub #(
  parameter int unsigned W = 65
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         sub_i,
  output logic [W-1:0] sum_o
);

  logic [W-1:0] b_inv;

  assign b_inv = sub_i ? ~b_i : b_i;
  assign sum_o = a_i + b_inv + W'(sub_i);

endmodule

// File: rtl/core/dts_cfg.sv
// ----------------------------------------------------------------------------
// dts_cfg
// Period and catch-up limit registers; zero writes fall back to defaults.
// ----------------------------------------------------------------------------
module dts_cfg import dts_pkg::*; #(
  parameter int unsigned TIME_WIDTH  = DEF_TIME_WIDTH,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  output logic [TIME_WIDTH-1:0]  period_o,
  output logic [COUNT_WIDTH-1:0] limit_o
);

  function automatic logic [TIME_WIDTH-1:0] fix_period(input logic [CFG_DATA_W-1:0] v);
    logic [TIME_WIDTH-1:0] p;
    p = v[TIME_WIDTH-1:0];
    if (p == '0) begin
      p = DEFAULT_PERIOD[TIME_WIDTH-1:0];
    end
    if (p == '0) begin
      p = TIME_WIDTH'(1);
    end
    return p;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] fix_limit(input logic [CFG_DATA_W-1:0] v);
    logic [COUNT_WIDTH-1:0] l;
    l = v[COUNT_WIDTH-1:0];
    if (l == '0) begin
      l = DEFAULT_LIMIT[COUNT_WIDTH-1:0];
    end
    return l;
  endfunction

  logic [TIME_WIDTH-1:0]  period_q;
  logic [COUNT_WIDTH-1:0] limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= fix_period(DEFAULT_PERIOD);
      limit_q  <= fix_limit(DEFAULT_LIMIT);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_TICK_PERIOD:   period_q <= fix_period(cfg_wdata_i);
        REG_CATCHUP_LIMIT: limit_q  <= fix_limit(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  assign period_o = period_q;
  assign limit_o  = limit_q;

endmodule

// File: rtl/core/deadline_tick_scheduler_core.sv
// ----------------------------------------------------------------------------
// deadline_tick_scheduler_core
// Tick scheduler: start/stop/query beats against a wrapping deadline.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload
//  s_axis    in   tuser = action (2b), tdata = now_time (64b)
//  m_axis    out  tdata = due_ticks [31:0], skipped_ticks [63:32]
//  cfg       in   we / index / wdata, 0 = tick_period, 1 = catchup_limit
//
//  Start sets deadline = now + period; stop, ignored codes and a query while
//  stopped go straight to the result; a query that is not due ends after now -
//  deadline. A due query runs the restoring divide, one quotient bit per cycle
//  through the shared adder/subtractor, then counts and advances the deadline.
//  Reset: stopped, deadline 0, period 1000000, limit 1.
//  The result sits in an output register; the next input beat is taken while
//  it waits, and the sequencer holds its finished result until that frees up.
//
module deadline_tick_scheduler_core import dts_pkg::*; #(
  parameter int unsigned TIME_WIDTH  = DEF_TIME_WIDTH,
  parameter int unsigned COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [NOW_W-1:0]      s_axis_tdata_i,   // [63:0] now_time
  input  logic [ACTION_W-1:0]   s_axis_tuser_i,   // [1:0] action
  // result stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [OUT_DATA_W-1:0] m_axis_tdata_o,   // [31:0] due_ticks, [63:32] skipped_ticks
  // configuration
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int unsigned TW   = TIME_WIDTH;
  localparam int unsigned CW   = COUNT_WIDTH;
  localparam int unsigned AW   = TW + 1;
  localparam int unsigned XW   = ((TW > CW) ? TW : CW) + 1;
  localparam int unsigned CNTW = $clog2(TW);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_START = 9'b000000010,
    ST_DIFF  = 9'b000000100,
    ST_DIV   = 9'b000001000,
    ST_COUNT = 9'b000010000,
    ST_ADV1  = 9'b000100000,
    ST_ADV2  = 9'b001000000,
    ST_FIX   = 9'b010000000,
    ST_DONE  = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [TW-1:0] period;
  logic [CW-1:0] limit;

  dts_cfg #(
    .TIME_WIDTH (TW),
    .COUNT_WIDTH(CW)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_wdata_i(cfg_wdata_i),
    .period_o   (period),
    .limit_o    (limit)
  );

  // scheduler state
  logic          running_q;
  logic [TW-1:0] deadline_q;

  // per-beat working registers
  logic [TW-1:0]   now_q;
  logic [TW-1:0]   quo_q;   // dividend shifts out, quotient shifts in
  logic [TW-1:0]   rem_q;
  logic [TW-1:0]   tmp_q;
  logic [CNTW-1:0] cnt_q;
  logic            sat_q;
  logic [CW-1:0]   raw_q;
  logic [CW-1:0]   due_q;
  logic [CW-1:0]   skip_q;

  // output register
  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  // shared adder/subtractor
  logic [AW-1:0] alu_a, alu_b, alu_sum;
  logic          alu_sub;
  logic          alu_neg;

  dts_addsub #(.W(AW)) u_alu (
    .a_i  (alu_a),
    .b_i  (alu_b),
    .sub_i(alu_sub),
    .sum_o(alu_sum)
  );

  assign alu_neg = alu_sum[TW];

  logic [TW-1:0] period_shl;
  assign period_shl = period << CW;   // period * 2^CW, wraps like the deadline

  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_sub = 1'b0;
    case (state_q)
      ST_START: begin
        alu_a = {1'b0, now_q};
        alu_b = {1'b0, period};
      end
      ST_DIFF, ST_FIX: begin
        alu_a   = {1'b0, now_q};
        alu_b   = {1'b0, deadline_q};
        alu_sub = 1'b1;
      end
      ST_DIV: begin
        alu_a   = {rem_q, quo_q[TW-1]};
        alu_b   = {1'b0, period};
        alu_sub = 1'b1;
      end
      ST_ADV1: begin
        // saturated: deadline + (2^CW)*period, then minus period below
        // otherwise: now - rem, then plus period below
        if (sat_q) begin
          alu_a = {1'b0, deadline_q};
          alu_b = {1'b0, period_shl};
        end else begin
          alu_a   = {1'b0, now_q};
          alu_b   = {1'b0, rem_q};
          alu_sub = 1'b1;
        end
      end
      ST_ADV2: begin
        alu_a   = {1'b0, tmp_q};
        alu_b   = {1'b0, period};
        alu_sub = sat_q;
      end
      default: ;
    endcase
  end

  // tick count from the quotient
  logic          cnt_sat;
  logic [CW-1:0] cnt_raw;
  logic [CW-1:0] cnt_due;

  assign cnt_sat = XW'(quo_q) >= XW'({CW{1'b1}});
  assign cnt_raw = cnt_sat ? {CW{1'b1}} : CW'(quo_q) + CW'(1);
  assign cnt_due = (raw_q > limit) ? limit : raw_q;

  logic s_fire, m_fire, out_free;
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire   = m_axis_tvalid_o && m_axis_tready_i;
  assign out_free = !out_valid_q || m_axis_tready_i;

  assign s_axis_tready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          case (action_e'(s_axis_tuser_i))
            ACT_START: state_d = ST_START;
            ACT_QUERY: state_d = running_q ? ST_DIFF : ST_DONE;
            default:   state_d = ST_DONE;
          endcase
        end
      end
      ST_START: state_d = ST_DONE;
      ST_DIFF:  state_d = alu_neg ? ST_DONE : ST_DIV;
      ST_DIV:   state_d = (cnt_q == '0) ? ST_COUNT : ST_DIV;
      ST_COUNT: state_d = ST_ADV1;
      ST_ADV1:  state_d = ST_ADV2;
      ST_ADV2:  state_d = ST_FIX;
      ST_FIX:   state_d = alu_neg ? ST_DONE : ST_START;   // deadline not past now: re-arm
      ST_DONE:  state_d = out_free ? ST_IDLE : ST_DONE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      running_q   <= 1'b0;
      deadline_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_IDLE && s_fire &&
          action_e'(s_axis_tuser_i) == ACT_STOP) begin
        running_q  <= 1'b0;
        deadline_q <= '0;
      end
      if (state_q == ST_START) begin
        running_q  <= 1'b1;
        deadline_q <= alu_sum[TW-1:0];
      end
      if (state_q == ST_ADV2) begin
        deadline_q <= alu_sum[TW-1:0];
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          now_q  <= s_axis_tdata_i[TW-1:0];
          due_q  <= '0;
          skip_q <= '0;
        end
      end
      ST_DIFF: begin
        quo_q <= alu_sum[TW-1:0];
        rem_q <= '0;
        cnt_q <= CNTW'(TW - 1);
      end
      ST_DIV: begin
        cnt_q <= cnt_q - CNTW'(1);
        if (!alu_neg) begin
          rem_q <= alu_sum[TW-1:0];
          quo_q <= {quo_q[TW-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[TW-2:0], quo_q[TW-1]};
          quo_q <= {quo_q[TW-2:0], 1'b0};
        end
      end
      ST_COUNT: begin
        sat_q <= cnt_sat;
        raw_q <= cnt_raw;
      end
      ST_ADV1: begin
        tmp_q  <= alu_sum[TW-1:0];
        due_q  <= cnt_due;
        skip_q <= raw_q - cnt_due;
      end
      ST_DONE: begin
        if (out_free) begin
          out_data_q <= {SKIP_W'(skip_q), DUE_W'(due_q)};
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule
